### design/lom_pkg.sv
// ----------------------------------------------------------------------------
// lom_pkg
// Shared constants for the limit order matcher.
// ----------------------------------------------------------------------------
package lom_pkg;

	localparam int ORDER_CAPACITY_DEF = 32;
	localparam int PRICE_BITS_DEF     = 10;
	localparam int QTY_BITS_DEF       = 16;
	localparam int ID_BITS_DEF        = 32;
	localparam int STAMP_BITS         = 32;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

endpackage

### design/lom_if.sv
// ----------------------------------------------------------------------------
// lom_order_if / lom_result_if
// Valid/ready channels for incoming orders and for result items.
// ----------------------------------------------------------------------------
interface lom_order_if import lom_pkg::*; #(
	parameter int ID_BITS    = ID_BITS_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF,
	parameter int QTY_BITS   = QTY_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  side;
	logic [ID_BITS-1:0]    order_id;
	logic [PRICE_BITS-1:0] limit_price;
	logic [QTY_BITS-1:0]   quantity;

	modport source (output valid, side, order_id, limit_price, quantity, input ready);
	modport sink   (input valid, side, order_id, limit_price, quantity, output ready);
endinterface

interface lom_result_if import lom_pkg::*; #(
	parameter int ID_BITS    = ID_BITS_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF,
	parameter int QTY_BITS   = QTY_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  is_trade;
	logic [ID_BITS-1:0]    seller_id;
	logic [ID_BITS-1:0]    buyer_id;
	logic [PRICE_BITS-1:0] fill_price;
	logic [QTY_BITS-1:0]   fill_qty;
	logic [QTY_BITS-1:0]   rested_qty;
	logic                  book_full;
	logic                  last;

	modport source (output valid, is_trade, seller_id, buyer_id, fill_price, fill_qty,
		rested_qty, book_full, last, input ready);
	modport sink   (input valid, is_trade, seller_id, buyer_id, fill_price, fill_qty,
		rested_qty, book_full, last, output ready);
endinterface

### design/lom_ram.sv
// ----------------------------------------------------------------------------
// lom_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lom_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### design/limit_order_matcher_top.sv
// ----------------------------------------------------------------------------
// limit_order_matcher_top
// Price-time priority limit order book with one order store in RAM.
//
// ord: one limit order per transfer (side, order_id, limit_price, quantity).
// res: result items; zero or more trades, then one status item with last set.
// An order is taken only while the block is idle. Each fill walks the whole
// store, one entry read per cycle from the RAM, in the scan step; a decide
// step and a trade step follow. An order whose last walk finds no cross goes
// from its decide step to the status step; one whose quantity runs out on a
// fill goes there from its trade step. At most ORDER_CAPACITY fills.
// The store walk is the limit on rate; the RAM read port serves one entry a
// cycle. Results go through a single output register: when the receiver
// stalls, the block holds in its trade or status step until the register
// frees. Reset clears all valid bits, the arrival counter and the output
// valid flag; RAM contents are not cleared, entries are used only while valid.
// ----------------------------------------------------------------------------
module limit_order_matcher_top import lom_pkg::*; #(
	parameter int ORDER_CAPACITY = ORDER_CAPACITY_DEF,
	parameter int PRICE_BITS     = PRICE_BITS_DEF,
	parameter int QTY_BITS       = QTY_BITS_DEF,
	parameter int ID_BITS        = ID_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	lom_order_if.sink     ord,
	lom_result_if.source  res
);
	localparam int IDX_W = $clog2(ORDER_CAPACITY);
	localparam int CNT_W = $clog2(ORDER_CAPACITY + 1);
	localparam int O_ID  = 0;
	localparam int O_SD  = O_ID + ID_BITS;
	localparam int O_PR  = O_SD + 1;
	localparam int O_QT  = O_PR + PRICE_BITS;
	localparam int O_ST  = O_QT + QTY_BITS;
	localparam int WW    = O_ST + STAMP_BITS;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(ORDER_CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER_CAPACITY - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_TRADE  = 3'd3;
	localparam logic [2:0] ST_STATUS = 3'd4;

	logic [2:0]            state_q;
	logic                  side_q;
	logic [ID_BITS-1:0]    id_q;
	logic [PRICE_BITS-1:0] limit_q;
	logic [QTY_BITS-1:0]   qty_q;
	logic [CNT_W-1:0]      fills_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic                  rd_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [ORDER_CAPACITY-1:0] valid_q;
	logic [STAMP_BITS-1:0] arrival_q;

	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [WW-1:0]         best_word_q;
	logic [STAMP_BITS-1:0] best_age_q;

	logic                  ovalid_q;
	logic                  o_trade_q, o_full_q, o_last_q;
	logic [ID_BITS-1:0]    o_seller_q, o_buyer_q;
	logic [PRICE_BITS-1:0] o_price_q;
	logic [QTY_BITS-1:0]   o_fill_q, o_rested_q;

	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [WW-1:0]         wdata;
	logic                  re;
	logic [WW-1:0]         rdata;

	logic [PRICE_BITS-1:0] c_price, b_price;
	logic [QTY_BITS-1:0]   b_qty, fill, b_left, q_left;
	logic [STAMP_BITS-1:0] c_age;
	logic                  c_ok, c_better;
	logic                  out_free;
	logic                  out_load;
	logic                  free_any;
	logic [IDX_W-1:0]      free_idx;

	lom_ram #(.WIDTH(WW), .DEPTH(ORDER_CAPACITY), .AW(IDX_W)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(rd_cnt_q[IDX_W-1:0]), .rdata(rdata)
	);

	assign ord.ready = (state_q == ST_IDLE);
	assign out_free  = !ovalid_q || res.ready;
	assign out_load  = out_free && (state_q == ST_TRADE || state_q == ST_STATUS);
	assign re        = (state_q == ST_SCAN) && (rd_cnt_q < CAP_CNT);

	// candidate evaluation
	always_comb begin
		c_price      = rdata[O_PR +: PRICE_BITS];
		c_age        = arrival_q - rdata[O_ST +: STAMP_BITS];
		b_price      = best_word_q[O_PR +: PRICE_BITS];
		c_ok = rd_s1 && valid_q[idx_s1] && (rdata[O_SD] != side_q)
			&& ((side_q == SIDE_BUY) ? (c_price <= limit_q) : (c_price >= limit_q));
		if (!found_q) begin
			c_better = 1'b1;
		end else if (c_price != b_price) begin
			c_better = (side_q == SIDE_BUY) ? (c_price < b_price) : (c_price > b_price);
		end else begin
			c_better = c_age > best_age_q;
		end
	end

	always_comb begin
		b_qty  = best_word_q[O_QT +: QTY_BITS];
		fill   = (b_qty <= qty_q) ? b_qty : qty_q;
		b_left = b_qty - fill;
		q_left = qty_q - fill;
	end

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = ORDER_CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = best_idx_q;
		wdata = best_word_q;
		wdata[O_QT +: QTY_BITS] = b_left;
		if (state_q == ST_TRADE && out_free) begin
			we = 1'b1;
		end else if (state_q == ST_STATUS && out_free && qty_q != '0 && free_any) begin
			we    = 1'b1;
			waddr = free_idx;
			wdata = {arrival_q, qty_q, limit_q, side_q, id_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			arrival_q <= '0;
			ovalid_q  <= 1'b0;
			rd_s1     <= 1'b0;
			found_q   <= 1'b0;
			fills_q   <= '0;
			rd_cnt_q  <= '0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (res.ready) begin
				ovalid_q <= 1'b0;
			end
			rd_s1 <= re;
			case (state_q)
				ST_IDLE: begin
					if (ord.valid) begin
						fills_q  <= '0;
						rd_cnt_q <= '0;
						found_q  <= 1'b0;
						state_q  <= (ord.quantity == '0) ? ST_STATUS : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (re) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (c_ok && c_better) begin
						found_q <= 1'b1;
					end
					if (rd_s1 && idx_s1 == LAST_IDX) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= found_q ? ST_TRADE : ST_STATUS;
				end
				ST_TRADE: begin
					if (out_free) begin
						fills_q  <= fills_q + 1'b1;
						if (b_left == '0) begin
							valid_q[best_idx_q] <= 1'b0;
						end
						rd_cnt_q <= '0;
						found_q  <= 1'b0;
						state_q  <= (q_left == '0 || fills_q + 1'b1 == CAP_CNT)
							? ST_STATUS : ST_SCAN;
					end
				end
				ST_STATUS: begin
					if (out_free) begin
						if (qty_q != '0 && free_any) begin
							valid_q[free_idx] <= 1'b1;
							arrival_q <= arrival_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (state_q == ST_IDLE && ord.valid) begin
			side_q  <= ord.side;
			id_q    <= ord.order_id;
			limit_q <= ord.limit_price;
			qty_q   <= ord.quantity;
		end
		if (state_q == ST_SCAN && c_ok && c_better) begin
			best_idx_q  <= idx_s1;
			best_word_q <= rdata;
			best_age_q  <= c_age;
		end
		if (state_q == ST_TRADE && out_free) begin
			qty_q      <= q_left;
			o_trade_q  <= 1'b1;
			o_seller_q <= (side_q == SIDE_BUY) ? best_word_q[O_ID +: ID_BITS] : id_q;
			o_buyer_q  <= (side_q == SIDE_BUY) ? id_q : best_word_q[O_ID +: ID_BITS];
			o_price_q  <= b_price;
			o_fill_q   <= fill;
			o_rested_q <= '0;
			o_full_q   <= 1'b0;
			o_last_q   <= 1'b0;
		end
		if (state_q == ST_STATUS && out_free) begin
			o_trade_q  <= 1'b0;
			o_seller_q <= '0;
			o_buyer_q  <= '0;
			o_price_q  <= '0;
			o_fill_q   <= '0;
			o_rested_q <= (qty_q != '0 && free_any) ? qty_q : '0;
			o_full_q   <= (qty_q != '0 && !free_any);
			o_last_q   <= 1'b1;
		end
	end

	assign res.valid      = ovalid_q;
	assign res.is_trade   = o_trade_q;
	assign res.seller_id  = o_seller_q;
	assign res.buyer_id   = o_buyer_q;
	assign res.fill_price = o_price_q;
	assign res.fill_qty   = o_fill_q;
	assign res.rested_qty = o_rested_q;
	assign res.book_full  = o_full_q;
	assign res.last       = o_last_q;
endmodule

### design/lom_checker.sv
// ----------------------------------------------------------------------------
// lom_checker
// Port-level checks on the limit order matcher, bound to the top level.
// ----------------------------------------------------------------------------
module lom_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic is_trade,
	input logic last,
	input logic book_full,
	input logic fill_zero,
	input logic rested_zero
);
	a_one_order: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("order taken while busy");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_trade != last))
		else $error("trade/status marking mismatch");

	a_trade_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_trade |-> !fill_zero && !book_full && rested_zero)
		else $error("bad trade item");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && book_full |-> rested_zero)
		else $error("full with rested quantity");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(last))
		else $error("result dropped while stalled");
endmodule

bind limit_order_matcher_top lom_checker u_lom_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(ord.valid),
	.in_ready(ord.ready),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.is_trade(res.is_trade),
	.last(res.last),
	.book_full(res.book_full),
	.fill_zero(res.fill_qty == '0),
	.rested_zero(res.rested_qty == '0)
);
